// ===== sv/arpb_pkg.sv =====
// Shared types and constants for the address range to prefix block expander.
package arpb_pkg;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = ADDR_W + 1;
  localparam int LEN_W   = 6;
  localparam int LG_W    = 6;

  typedef struct packed {
    logic [ADDR_W-1:0]  start_addr;
    logic [COUNT_W-1:0] addr_count;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_base;
    logic [LEN_W-1:0]  prefix_len;
    logic              last_block;
  } out_res_t;

  // A classified range: clipped to the address space and never empty.
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] left;
  } range_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/arpb_front.sv =====
// Front end: takes requests, clips the count to the space, drops empty ranges.
module arpb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  arpb_pkg::in_req_t in_req,
  input  arpb_pkg::q_stat_t q_stat,
  output logic            push,
  output arpb_pkg::range_t  push_data
);
  import arpb_pkg::*;

  logic               hold_r;
  range_t             range_r;
  logic [COUNT_W-1:0] room;
  logic [COUNT_W-1:0] clipped;
  logic               accept;

  // Addresses from the start to the top of the space, inclusive.
  assign room    = {1'b1, {ADDR_W{1'b0}}} - {1'b0, in_req.start_addr};
  assign clipped = (in_req.addr_count > room) ? room : in_req.addr_count;

  assign push      = hold_r && !q_stat.full;
  assign push_data = range_r;
  assign in_stall  = hold_r && q_stat.full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (accept) begin
      hold_r <= (in_req.addr_count != '0);
    end else if (push) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      range_r.base <= in_req.start_addr;
      range_r.left <= clipped;
    end
  end

endmodule

// ===== sv/arpb_queue.sv =====
// Two-entry queue of classified ranges between the front and back ends.
module arpb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  arpb_pkg::range_t  push_data,
  input  logic              pop,
  output arpb_pkg::range_t  pop_data,
  output arpb_pkg::q_stat_t q_stat
);
  import arpb_pkg::*;

  range_t     slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign pop_data     = slot_r[rd_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== sv/arpb_back.sv =====
// Back end: walks one range and emits one aligned prefix block per cycle while its output is not held by out_stall.
module arpb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  arpb_pkg::q_stat_t   q_stat,
  output logic                pop,
  input  arpb_pkg::range_t    pop_data,
  output logic                out_valid,
  input  logic                out_stall,
  output arpb_pkg::out_res_t  out_res
);
  import arpb_pkg::*;

  logic               busy_r;
  logic [ADDR_W-1:0]  cur_r;
  logic [COUNT_W-1:0] left_r;
  logic               out_valid_r;
  out_res_t           out_res_r;

  logic [COUNT_W-1:0] cur_ext;
  logic [COUNT_W-1:0] align;
  logic [COUNT_W-1:0] smear;
  logic [COUNT_W-1:0] top;
  logic [COUNT_W-1:0] size;
  logic [COUNT_W-1:0] left_nxt;
  logic [LG_W-1:0]    lg;
  logic               advance;

  assign cur_ext = {1'b0, cur_r};

  // Lowest set bit of the address; address zero allows the whole space.
  always_comb begin
    align = cur_ext & (~cur_ext + {{(COUNT_W-1){1'b0}}, 1'b1});
    if (cur_r == '0) begin
      align = {1'b1, {ADDR_W{1'b0}}};
    end
  end

  // Highest set bit of the remaining count.
  always_comb begin
    smear = left_r;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 32);
    top   = smear ^ (smear >> 1);
  end

  assign size     = (align < top) ? align : top;
  assign left_nxt = left_r - size;

  // Bit position of the one-hot block size.
  always_comb begin
    lg = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (size[i]) begin
        lg = lg | LG_W'(i);
      end
    end
  end

  assign advance   = busy_r && (!out_valid_r || !out_stall);
  assign pop       = !busy_r && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (advance && (left_nxt == '0)) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= pop_data.base;
      left_r <= pop_data.left;
    end else if (advance) begin
      cur_r  <= cur_r + size[ADDR_W-1:0];
      left_r <= left_nxt;
    end
    if (advance) begin
      out_res_r.block_base <= cur_r;
      out_res_r.prefix_len <= LEN_W'(ADDR_W) - lg;
      out_res_r.last_block <= (left_nxt == '0);
    end
  end

endmodule

// ===== sv/address_range_to_prefix_blocks.sv =====
// Top level: splits an address range into aligned prefix blocks, one per result.
// A request passes the front register, a queue slot and the back-end walk registers before its first block.
// Throughput: the back end emits one block per cycle while out_stall is low; a request that
// splits into n blocks (at most 62) holds the back end while it loads and emits those blocks.
// A zero-count request is dropped in the front end and takes no back-end time.
// Reset (synchronous, active low) empties the front register, the queue and the back end.
module address_range_to_prefix_blocks (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  arpb_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output arpb_pkg::out_res_t  out_res
);
  import arpb_pkg::*;

  // The front end clips each request to the top of the space and holds it
  // in one register until the queue takes it.
  logic    push;
  range_t  push_data;
  logic    pop;
  range_t  pop_data;
  q_stat_t q_stat;

  arpb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets new requests arrive while a long range is still being split.
  arpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // The back end picks the largest block allowed by the current address
  // alignment and the count left, steps past it, and registers the result.
  // Its output register keeps loading while the consumer stalls, as long as it is empty.
  arpb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
